>>> rtl/miami_npp_cell_top_assert.svh
// Assertion macros for the Miami NPP cell block.
// Used by the port checker; needs nothing else.
`ifndef MIAMI_NPP_CELL_TOP_ASSERT_SVH
`define MIAMI_NPP_CELL_TOP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define MNPP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mnpp: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define MNPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mnpp: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define MNPP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mnpp: reset check failed");

`endif

>>> rtl/mnpp_pkg.sv
// Shared constants and types for the Miami NPP cell block.
// No dependencies.
package mnpp_pkg;

  localparam int EXP_TERMS = 14;
  localparam int COS_TERMS = 8;

  typedef logic [29:0] exp_arg_t;
  typedef logic [30:0] q30_t;

  localparam q30_t        Q30_ONE      = 31'd1 << 30;
  localparam logic [24:0] X_OFFSET     = 25'd22062039;
  localparam logic [16:0] X_SLOPE      = 17'd124781;
  localparam logic [13:0] RAIN_SLOPE   = 14'd11140;
  localparam logic [31:0] RAD_SCALE    = 32'd2398762258;
  localparam logic [17:0] FULL_TURN    = 18'd184320;
  localparam logic [17:0] HALF_TURN    = 18'd92160;
  localparam logic [17:0] QUARTER_TURN = 18'd46080;
  localparam logic [17:0] THREE_QUART  = 18'd138240;
  localparam logic [15:0] NPP_MAX      = 16'd48000;
  localparam logic [14:0] CELL_HEIGHT_RST = 15'd256;

endpackage

>>> rtl/mnpp_in_if.sv
// Input channel of the Miami NPP cell block: one grid cell per item.
// No dependencies.
interface mnpp_in_if;
  logic               valid;
  logic               ready;
  logic               land_flag;
  logic [15:0]        rainfall_mm;
  logic signed [13:0] temperature;
  logic signed [15:0] latitude;

  modport source (output valid, land_flag, rainfall_mm, temperature, latitude,
                  input ready);
  modport sink   (input valid, land_flag, rainfall_mm, temperature, latitude,
                  output ready);
endinterface

>>> rtl/mnpp_out_if.sv
// Output channel of the Miami NPP cell block: one NPP value per item.
// No dependencies.
interface mnpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] npp;

  modport source (output valid, npp, input ready);
  modport sink   (input valid, npp, output ready);
endinterface

>>> rtl/mnpp_exp.sv
// Pipelined exp(-a/2^24) in Q30: 14-term series at a/32, then five squarings.
// Depends on mnpp_pkg.
module mnpp_exp (
  input  logic              clk,
  input  logic              en,
  input  mnpp_pkg::exp_arg_t a,
  output mnpp_pkg::q30_t     e
);
  import mnpp_pkg::*;

  localparam int NSQ = 5;

  logic [29:0]        z_m    [1:EXP_TERMS];
  logic [29:0]        z_d    [0:EXP_TERMS];
  logic               big_m  [1:EXP_TERMS];
  logic               big_d  [0:EXP_TERMS];
  logic [29:0]        n_m    [1:EXP_TERMS];
  logic signed [32:0] sum_m  [1:EXP_TERMS];
  logic signed [32:0] sum_d  [0:EXP_TERMS];
  q30_t               term_d [0:EXP_TERMS];
  q30_t               r_q    [1:NSQ];
  logic               big_s  [1:NSQ];
  q30_t               r0;

  always_ff @(posedge clk) begin
    if (en) begin
      z_d[0]    <= {a[28:0], 1'b0};
      big_d[0]  <= a[29];
      term_d[0] <= Q30_ONE;
      sum_d[0]  <= signed'({2'b00, Q30_ONE});
    end
  end

  for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
    localparam int SH = 30 + $clog2(k);
    localparam logic [31:0] RCP = 32'(((64'd1 << SH) + 64'(k) - 64'd1) / 64'(k));
    localparam bit ODD = (k % 2) == 1;
    logic [60:0] prod;
    logic [61:0] qprod;
    q30_t        term;

    assign prod  = 61'(term_d[k-1]) * 61'(z_d[k-1]);
    // exact floor divide by k through the scaled reciprocal
    assign qprod = 62'(n_m[k]) * 62'(RCP);
    assign term  = q30_t'(qprod >> SH);

    always_ff @(posedge clk) begin
      if (en) begin
        n_m[k]    <= prod[59:30];
        z_m[k]    <= z_d[k-1];
        big_m[k]  <= big_d[k-1];
        sum_m[k]  <= sum_d[k-1];
        term_d[k] <= term;
        z_d[k]    <= z_m[k];
        big_d[k]  <= big_m[k];
        sum_d[k]  <= ODD ? sum_m[k] - signed'({2'b00, term})
                         : sum_m[k] + signed'({2'b00, term});
      end
    end
  end

  assign r0 = sum_d[EXP_TERMS][32] ? '0 : sum_d[EXP_TERMS][30:0];

  for (genvar j = 1; j <= NSQ; j++) begin : g_sq
    q30_t        rin;
    logic        bin;
    logic [61:0] sq;

    if (j == 1) begin : g_first
      assign rin = r0;
      assign bin = big_d[EXP_TERMS];
    end else begin : g_rest
      assign rin = r_q[j-1];
      assign bin = big_s[j-1];
    end

    assign sq = (62'(rin) * 62'(rin)) + (62'd1 << 29);

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[j]   <= q30_t'(sq >> 30);
        big_s[j] <= bin;
      end
    end
  end

  // large arguments give zero
  assign e = big_s[NSQ] ? '0 : r_q[NSQ];

endmodule

>>> rtl/miami_npp_cell_top.sv
// Miami NPP cell block: top level, cosine series, divider and output stage.
// Depends on mnpp_pkg, mnpp_in_if, mnpp_out_if and mnpp_exp.
//
// Usage
//   grid carries one cell per item (land flag, rainfall, temperature,
//   lower latitude); prod returns one signed NPP value per item, in order.
//   cfg_we/cfg_wdata write cell_height; write it only while no item is in
//   flight.
//   The pipeline has 55 register stages; prod.valid is the valid bit of the
//   last stage. While prod is not stalled, one item is taken every cycle; the
//   depth is set by the 14-term exp series (two stages a term), five
//   squarings and the 16-stage restoring divider in series.
//   Every stage moves on a common enable: when prod holds a result that is
//   not taken, the whole pipeline holds and grid.ready drops, so nothing is
//   lost or repeated. Bubbles inside the pipeline hold as well.
//   Reset is synchronous: valid bits clear, cell_height returns to 256 and
//   grid.ready is low while rst is high.
module miami_npp_cell_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  mnpp_in_if.sink     grid,
  mnpp_out_if.source  prod
);
  import mnpp_pkg::*;

  localparam int LAST = 55;

  logic               en;
  logic [14:0]        cell_height;
  logic               v       [1:LAST];

  // stage 1
  logic signed [31:0] x_c;
  logic signed [18:0] c_c;
  logic signed [18:0] cm_c;
  logic [29:0]        ax1;
  logic [29:0]        ar1;
  logic [17:0]        c1;
  logic               xneg_d  [1:35];
  logic               land_d  [1:54];
  // stage 2..4
  logic [15:0]        u_c;
  logic               neg_c;
  logic [15:0]        u2;
  logic               neg_d   [2:54];
  logic [47:0]        rad_c;
  logic [31:0]        rad3;
  logic [63:0]        rsq_c;
  // cosine series
  logic [31:0]        cz_m    [1:COS_TERMS];
  logic [31:0]        cz_d    [0:COS_TERMS];
  logic [31:0]        cn_m    [1:COS_TERMS];
  logic signed [34:0] csum_m  [1:COS_TERMS];
  logic signed [34:0] csum_d  [0:COS_TERMS];
  logic [31:0]        cterm_d [0:COS_TERMS];
  q30_t               cos_d   [21:53];
  // exponentials
  q30_t               et;
  q30_t               er;
  // limits and divider
  logic [31:0]        den_c;
  logic [46:0]        num_c;
  logic [46:0]        lr_c;
  logic [15:0]        limr_d  [36:52];
  logic [46:0]        rem_q   [0:16];
  logic [31:0]        den_q   [0:16];
  logic [15:0]        quo_q   [0:16];
  // tail
  logic [15:0]        m53;
  logic [46:0]        mag_c;
  logic [15:0]        mag54;
  logic signed [16:0] npp55;

  assign en         = !v[LAST] || prod.ready;
  assign grid.ready = en && !rst;
  assign prod.valid = v[LAST];
  assign prod.npp   = npp55;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_height <= CELL_HEIGHT_RST;
    end else if (cfg_we) begin
      cell_height <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LAST; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[1] <= grid.valid;
      for (int i = 2; i <= LAST; i++) v[i] <= v[i-1];
    end
  end

  // stage 1: exponent arguments and the centre angle reduced into one turn
  assign x_c  = signed'(32'(X_OFFSET)) - signed'(32'(X_SLOPE)) * 32'(grid.temperature);
  assign c_c  = (19'(grid.latitude) <<< 1) + signed'(19'(cell_height));
  assign cm_c = c_c[18] ? c_c + signed'(19'(FULL_TURN)) : c_c;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1       <= x_c[31] ? 30'(-x_c) : x_c[29:0];
      ar1       <= 30'(grid.rainfall_mm) * 30'(RAIN_SLOPE);
      c1        <= cm_c[17:0];
      xneg_d[1] <= x_c[31];
      land_d[1] <= grid.land_flag;
      for (int i = 2; i <= 35; i++) xneg_d[i] <= xneg_d[i-1];
      for (int i = 2; i <= 54; i++) land_d[i] <= land_d[i-1];
    end
  end

  // stage 2: fold into the first quadrant
  always_comb begin
    priority if (c1 <= QUARTER_TURN) begin
      u_c   = c1[15:0];
      neg_c = 1'b0;
    end else if (c1 <= HALF_TURN) begin
      u_c   = 16'(HALF_TURN - c1);
      neg_c = 1'b1;
    end else if (c1 <= THREE_QUART) begin
      u_c   = 16'(c1 - HALF_TURN);
      neg_c = 1'b1;
    end else begin
      u_c   = 16'(FULL_TURN - c1);
      neg_c = 1'b0;
    end
  end

  assign rad_c = (48'(u2) * 48'(RAD_SCALE)) + (48'd1 << 15);
  assign rsq_c = 64'(rad3) * 64'(rad3);

  always_ff @(posedge clk) begin
    if (en) begin
      u2         <= u_c;
      neg_d[2]   <= neg_c;
      for (int i = 3; i <= 54; i++) neg_d[i] <= neg_d[i-1];
      rad3       <= rad_c[47:16];
      cz_d[0]    <= rsq_c[61:30];
      cterm_d[0] <= 32'(Q30_ONE);
      csum_d[0]  <= signed'(35'(Q30_ONE));
    end
  end

  // cosine Taylor series, two stages a term
  for (genvar k = 1; k <= COS_TERMS; k++) begin : g_cos
    localparam int KD = (2 * k - 1) * (2 * k);
    localparam int SH = 32 + $clog2(KD);
    localparam logic [33:0] RCP = 34'(((64'd1 << SH) + 64'(KD) - 64'd1) / 64'(KD));
    localparam bit ODD = (k % 2) == 1;
    logic [63:0] prod_c;
    logic [65:0] qprod;
    logic [31:0] term;

    assign prod_c = 64'(cterm_d[k-1]) * 64'(cz_d[k-1]);
    assign qprod  = 66'(cn_m[k]) * 66'(RCP);
    assign term   = 32'(qprod >> SH);

    always_ff @(posedge clk) begin
      if (en) begin
        cn_m[k]    <= prod_c[61:30];
        cz_m[k]    <= cz_d[k-1];
        csum_m[k]  <= csum_d[k-1];
        cterm_d[k] <= term;
        cz_d[k]    <= cz_m[k];
        csum_d[k]  <= ODD ? csum_m[k] - signed'(35'(term))
                          : csum_m[k] + signed'(35'(term));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp to 0..1
      if (csum_d[COS_TERMS][34]) begin
        cos_d[21] <= '0;
      end else if (csum_d[COS_TERMS] > signed'(35'(Q30_ONE))) begin
        cos_d[21] <= Q30_ONE;
      end else begin
        cos_d[21] <= csum_d[COS_TERMS][30:0];
      end
      for (int i = 22; i <= 53; i++) cos_d[i] <= cos_d[i-1];
    end
  end

  mnpp_exp u_exp_t (.clk(clk), .en(en), .a(ax1), .e(et));
  mnpp_exp u_exp_r (.clk(clk), .en(en), .a(ar1), .e(er));

  // stage 36: temperature numerator and denominator, rain limit
  assign den_c = 32'(Q30_ONE) + 32'(et);
  assign num_c = xneg_d[35] ? (47'(NPP_MAX) << 30) + 47'(den_c >> 1)
                            : 47'(NPP_MAX) * 47'(et) + 47'(den_c >> 1);
  assign lr_c  = 47'(NPP_MAX) * 47'(Q30_ONE - er) + (47'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]    <= num_c;
      den_q[0]    <= den_c;
      quo_q[0]    <= '0;
      limr_d[36]  <= lr_c[45:30];
      for (int i = 37; i <= 52; i++) limr_d[i] <= limr_d[i-1];
    end
  end

  // restoring divider, one quotient bit a stage
  for (genvar j = 0; j < 16; j++) begin : g_div
    localparam int B = 15 - j;
    logic [47:0] trial;
    logic        take;

    assign trial = 48'(den_q[j]) << B;
    assign take  = {1'b0, rem_q[j]} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1] <= take ? rem_q[j] - trial[46:0] : rem_q[j];
        den_q[j+1] <= den_q[j];
        quo_q[j+1] <= quo_q[j] | (16'(take) << B);
      end
    end
  end

  assign mag_c = 47'(cos_d[53]) * 47'(m53) + (47'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      m53   <= (quo_q[16] < limr_d[52]) ? quo_q[16] : limr_d[52];
      mag54 <= mag_c[45:30];
      // sea cells give zero
      if (!land_d[54]) begin
        npp55 <= '0;
      end else if (neg_d[54]) begin
        npp55 <= -signed'(17'(mag54));
      end else begin
        npp55 <= signed'(17'(mag54));
      end
    end
  end

endmodule

>>> rtl/mnpp_chk.sv
// Port checker for the Miami NPP cell block, bound to its top level.
// Depends on miami_npp_cell_top_assert.svh.
`include "miami_npp_cell_top_assert.svh"

module mnpp_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] npp
);

  // a stalled result stays put
  `MNPP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(npp))
  // reset empties the pipeline
  `MNPP_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid)
  // a stalled result holds back the input side
  `MNPP_ASSERT_SAME(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready)
  // an empty output stage never blocks intake
  `MNPP_ASSERT_SAME(a_free_takes, clk, rst, !out_valid || out_ready, in_ready)

endmodule

bind miami_npp_cell_top mnpp_chk u_mnpp_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(grid.valid),
  .in_ready(grid.ready),
  .out_valid(prod.valid),
  .out_ready(prod.ready),
  .npp(prod.npp)
);
